@@ rtl/core/idle_fading_led_colour_controller_top_defines.svh @@
// Assertion macros used by the checker file of the LED colour controller.
// No dependencies; include by bare file name.
`ifndef IDLE_FADING_LED_COLOUR_CONTROLLER_TOP_DEFINES_SVH
`define IDLE_FADING_LED_COLOUR_CONTROLLER_TOP_DEFINES_SVH

// Clocked implication check, disabled while reset is asserted.
`define IFLCC_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Same check without the reset guard, for properties that hold through reset.
`define IFLCC_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

@@ rtl/core/iflcc_pkg.sv @@
// Shared types and constants for the idle-fading LED colour controller.
// No dependencies.
package iflcc_pkg;

    localparam logic       KIND_TICK = 1'b0;
    localparam logic       KIND_KEY  = 1'b1;

    localparam logic [3:0] COL_RESET = 4'd0;
    localparam logic [3:0] ROW_RST0  = 4'd0;
    localparam logic [3:0] ROW_RST1  = 4'd3;
    localparam logic [3:0] ROW_RST2  = 4'd5;
    localparam logic [3:0] ROW_RST3  = 4'd8;
    localparam logic [3:0] RESET_ALL = 4'hf;

    localparam logic [7:0]  TICK_DIVIDE_RST   = 8'd20;
    localparam logic [14:0] OFF_THRESHOLD_RST = 15'd20000;

    localparam logic       CFG_TICK_DIVIDE   = 1'b0;
    localparam logic       CFG_OFF_THRESHOLD = 1'b1;

    // Idle-derived values after the current event, for the colour stage
    typedef struct packed {
        logic       update;
        logic       dark;
        logic [7:0] dim;
        logic [7:0] hue_off;
        logic [7:0] sat_off;
    } idle_info_t;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] level;
        logic       light_write;
        logic       reset_request;
    } result_t;

endpackage

@@ rtl/core/idle_fading_led_colour_controller_top.sv @@
// Top level of the idle-fading LED colour controller: config registers and
// the event path. Depends on iflcc_pkg, iflcc_reset_keys, iflcc_idle_track,
// iflcc_colour_glide and iflcc_out_buf.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------------
//   config  | in        | cfg_write_en           | cfg_index, cfg_data
//   event   | in        | in_valid / in_ready    | kind, pressed, key_row, key_col, layer_mask
//   result  | out       | out_valid / out_ready  | hue, saturation, level, light_write,
//           |           |                        | reset_request
//
// One event per cycle while in_ready is high. Key, idle and colour state update at the
// event transfer; its result is registered in the output register, or in the skid entry
// while the output register still holds an unpopped result. The skid entry keeps in_ready
// high while one result waits with out_ready low; in_ready drops only while two results wait.
// Reset: idle and tick counts clear, hue 29 (target 30), level target 255.
module idle_fading_led_colour_controller_top import iflcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic        pressed,
    input  logic [3:0]  key_row,
    input  logic [3:0]  key_col,
    input  logic [2:0]  layer_mask,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  hue,
    output logic [7:0]  saturation,
    output logic [7:0]  level,
    output logic        light_write,
    output logic        reset_request
);

    logic [7:0]  tick_divide_reg;
    logic [14:0] off_threshold_reg;
    logic        accept;
    logic        req;
    idle_info_t  info;
    result_t     res;
    result_t     res_out;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_divide_reg   <= TICK_DIVIDE_RST;
            off_threshold_reg <= OFF_THRESHOLD_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_TICK_DIVIDE:   tick_divide_reg   <= cfg_data[7:0];
                CFG_OFF_THRESHOLD: off_threshold_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    iflcc_reset_keys u_keys (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .kind    (kind),
        .pressed (pressed),
        .key_row (key_row),
        .key_col (key_col),
        .req     (req)
    );

    iflcc_idle_track u_idle (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .kind          (kind),
        .pressed       (pressed),
        .req           (req),
        .tick_divide   (tick_divide_reg),
        .off_threshold (off_threshold_reg),
        .info          (info)
    );

    iflcc_colour_glide u_glide (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .info        (info),
        .layer_mask  (layer_mask),
        .hue         (res.hue),
        .saturation  (res.saturation),
        .level       (res.level),
        .light_write (res.light_write)
    );

    assign res.reset_request = req;

    iflcc_out_buf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (res),
        .push_ready (in_ready),
        .pop_valid  (out_valid),
        .pop_ready  (out_ready),
        .pop_data   (res_out)
    );

    assign hue           = res_out.hue;
    assign saturation    = res_out.saturation;
    assign level         = res_out.level;
    assign light_write   = res_out.light_write;
    assign reset_request = res_out.reset_request;

endmodule

@@ rtl/core/iflcc_reset_keys.sv @@
// Tracks the four column-0 reset keys and flags the reset combination.
// Depends on iflcc_pkg.
module iflcc_reset_keys import iflcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       kind,
    input  logic       pressed,
    input  logic [3:0] key_row,
    input  logic [3:0] key_col,
    output logic       req
);

    logic [3:0] held_reg;
    logic [3:0] held_next;
    logic [3:0] key_bit;

    always_comb
    begin
        key_bit = 4'b0000;
        if (key_col == COL_RESET)
        begin
            case (key_row)
                ROW_RST0: key_bit = 4'b0001;
                ROW_RST1: key_bit = 4'b0010;
                ROW_RST2: key_bit = 4'b0100;
                ROW_RST3: key_bit = 4'b1000;
                default:  key_bit = 4'b0000;
            endcase
        end
    end

    always_comb
    begin
        if (kind != KIND_KEY)
            held_next = held_reg;
        else if (pressed)
            held_next = held_reg | key_bit;
        else
            held_next = held_reg & ~key_bit;
    end

    assign req = (kind == KIND_KEY) && (held_next == RESET_ALL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= 4'b0000;
        else if (accept)
            held_reg <= held_next;
    end

endmodule

@@ rtl/core/iflcc_idle_track.sv @@
// Scan tick divider, idle counter and incremental idle-to-colour mapping.
// Depends on iflcc_pkg.
module iflcc_idle_track import iflcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        kind,
    input  logic        pressed,
    input  logic        req,
    input  logic [7:0]  tick_divide,
    input  logic [14:0] off_threshold,
    output idle_info_t  info
);

    localparam logic [14:0] IDLE_MAX   = 15'd32767;
    localparam logic [14:0] IDLE_START = 15'd10;
    localparam logic [5:0]  PHASE_LAST = 6'd49;
    localparam logic [7:0]  DIM_MAX    = 8'd235;
    localparam logic [8:0]  RATIO_DEN  = 9'd235;
    localparam logic [8:0]  HUE_NUM    = 9'd210;
    localparam logic [8:0]  SAT_NUM    = 9'd175;

    logic [7:0]  tick_reg,  tick_next;
    logic [14:0] idle_reg,  idle_next;
    logic [5:0]  phase_reg, phase_next;
    logic [7:0]  dim_reg,   dim_next;
    logic [7:0]  hue_off_reg, hue_off_next;
    logic [7:0]  hue_frac_reg, hue_frac_next;
    logic [7:0]  sat_off_reg, sat_off_next;
    logic [7:0]  sat_frac_reg, sat_frac_next;

    logic [7:0]  tick_inc;
    logic        divided;
    logic        step;
    logic        clear;
    logic [8:0]  hue_sum;
    logic [8:0]  sat_sum;

    assign tick_inc = tick_reg + 8'd1;
    assign divided  = (kind == KIND_TICK) && (tick_inc >= tick_divide);
    assign step     = divided && (idle_reg != IDLE_MAX);
    assign clear    = (kind == KIND_KEY) && pressed && !req;
    assign hue_sum  = {1'b0, hue_frac_reg} + HUE_NUM;
    assign sat_sum  = {1'b0, sat_frac_reg} + SAT_NUM;

    always_comb
    begin
        if (kind != KIND_TICK)
            tick_next = tick_reg;
        else if (divided)
            tick_next = 8'd0;
        else
            tick_next = tick_inc;
    end

    // dim = (idle - 10) / 50 capped at 235, kept as quotient and phase;
    // the hue and saturation offsets follow dim*210/235 and dim*175/235
    // as running fractions.
    always_comb
    begin
        idle_next     = idle_reg;
        phase_next    = phase_reg;
        dim_next      = dim_reg;
        hue_off_next  = hue_off_reg;
        hue_frac_next = hue_frac_reg;
        sat_off_next  = sat_off_reg;
        sat_frac_next = sat_frac_reg;
        if (clear)
        begin
            idle_next     = 15'd0;
            phase_next    = 6'd0;
            dim_next      = 8'd0;
            hue_off_next  = 8'd0;
            hue_frac_next = 8'd0;
            sat_off_next  = 8'd0;
            sat_frac_next = 8'd0;
        end
        else if (step)
        begin
            idle_next = idle_reg + 15'd1;
            if (idle_reg >= IDLE_START)
            begin
                if (phase_reg != PHASE_LAST)
                    phase_next = phase_reg + 6'd1;
                else
                begin
                    phase_next = 6'd0;
                    if (dim_reg != DIM_MAX)
                    begin
                        dim_next = dim_reg + 8'd1;
                        if (hue_sum >= RATIO_DEN)
                        begin
                            hue_frac_next = 8'(hue_sum - RATIO_DEN);
                            hue_off_next  = hue_off_reg + 8'd1;
                        end
                        else
                            hue_frac_next = hue_sum[7:0];
                        if (sat_sum >= RATIO_DEN)
                        begin
                            sat_frac_next = 8'(sat_sum - RATIO_DEN);
                            sat_off_next  = sat_off_reg + 8'd1;
                        end
                        else
                            sat_frac_next = sat_sum[7:0];
                    end
                end
            end
        end
    end

    always_comb
    begin
        info.update  = step || ((kind == KIND_KEY) && !req);
        info.dark    = (idle_next >= IDLE_START) && (idle_next > off_threshold);
        info.dim     = dim_next;
        info.hue_off = hue_off_next;
        info.sat_off = sat_off_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= 8'd0;
            idle_reg     <= 15'd0;
            phase_reg    <= 6'd0;
            dim_reg      <= 8'd0;
            hue_off_reg  <= 8'd0;
            hue_frac_reg <= 8'd0;
            sat_off_reg  <= 8'd0;
            sat_frac_reg <= 8'd0;
        end
        else if (accept)
        begin
            tick_reg     <= tick_next;
            idle_reg     <= idle_next;
            phase_reg    <= phase_next;
            dim_reg      <= dim_next;
            hue_off_reg  <= hue_off_next;
            hue_frac_reg <= hue_frac_next;
            sat_off_reg  <= sat_off_next;
            sat_frac_reg <= sat_frac_next;
        end
    end

endmodule

@@ rtl/core/iflcc_colour_glide.sv @@
// Target colour selection and 63/64 smoothing of hue, saturation and level.
// Depends on iflcc_pkg.
module iflcc_colour_glide import iflcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  idle_info_t info,
    input  logic [2:0] layer_mask,
    output logic [7:0] hue,
    output logic [7:0] saturation,
    output logic [7:0] level,
    output logic       light_write
);

    localparam logic [7:0] HUE_RST      = 8'd29;
    localparam logic [7:0] HUE_TGT_RST  = 8'd30;
    localparam logic [7:0] HUE_BASE     = 8'd10;
    localparam logic [7:0] SAT_BASE     = 8'd80;
    localparam logic [7:0] LEVEL_FULL   = 8'd255;
    localparam logic [7:0] LAYER1_HUE   = 8'd0;
    localparam logic [7:0] LAYER2_HUE   = 8'd80;
    localparam logic [7:0] LAYER_SAT    = 8'd250;

    logic [7:0] cur_hue_reg, cur_sat_reg, cur_level_reg;
    logic [7:0] tgt_hue_reg, tgt_hue_next;
    logic [7:0] tgt_sat, tgt_level;
    logic [7:0] hue_step, sat_step, level_step;
    logic       differ;
    logic       stepped;

    // c = (63c + t) / 64, then one more unit toward t
    function automatic logic [7:0] glide(input logic [7:0] c, input logic [7:0] t);
        logic [13:0] acc;
        logic [7:0]  n;
        acc = ({c, 6'b000000} - {6'b000000, c}) + {6'b000000, t};
        n   = acc[13:6];
        if (n < t)
            n = n + 8'd1;
        else if (n > t)
            n = n - 8'd1;
        return n;
    endfunction

    always_comb
    begin
        tgt_hue_next = tgt_hue_reg;
        tgt_sat      = SAT_BASE + info.sat_off;
        tgt_level    = info.dark ? 8'd0 : (LEVEL_FULL - info.dim);
        if (layer_mask == 3'b000)
            tgt_hue_next = HUE_BASE + info.hue_off;
        if (layer_mask[1])
        begin
            tgt_hue_next = LAYER1_HUE;
            tgt_sat      = LAYER_SAT;
        end
        if (layer_mask[2])
        begin
            tgt_hue_next = LAYER2_HUE;
            tgt_sat      = LAYER_SAT;
        end
    end

    assign differ     = (tgt_level != cur_level_reg) || (tgt_hue_next != cur_hue_reg) ||
                        (tgt_sat != cur_sat_reg);
    assign stepped    = info.update && differ;
    assign hue_step   = glide(cur_hue_reg, tgt_hue_next);
    assign sat_step   = glide(cur_sat_reg, tgt_sat);
    assign level_step = glide(cur_level_reg, tgt_level);

    assign hue         = stepped ? hue_step   : cur_hue_reg;
    assign saturation  = stepped ? sat_step   : cur_sat_reg;
    assign level       = stepped ? level_step : cur_level_reg;
    assign light_write = stepped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_hue_reg   <= HUE_RST;
            cur_sat_reg   <= 8'd0;
            cur_level_reg <= 8'd0;
            tgt_hue_reg   <= HUE_TGT_RST;
        end
        else if (accept && info.update)
        begin
            tgt_hue_reg   <= tgt_hue_next;
            cur_hue_reg   <= hue;
            cur_sat_reg   <= saturation;
            cur_level_reg <= level;
        end
    end

endmodule

@@ rtl/core/iflcc_out_buf.sv @@
// Two-entry result buffer: output register plus skid entry.
// Depends on iflcc_pkg.
module iflcc_out_buf import iflcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    push_ready,
    output logic    pop_valid,
    input  logic    pop_ready,
    output result_t pop_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg, main_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign push_ready = !skid_valid_reg;
    assign pop_valid  = main_valid_reg;
    assign pop_data   = main_data_reg;
    assign pop        = main_valid_reg && pop_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
                main_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!main_valid_next)
            begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

@@ rtl/core/iflcc_checker.sv @@
// Port-level checks for the LED colour controller, bound to the top level.
// Depends on idle_fading_led_colour_controller_top_defines.svh.
`include "idle_fading_led_colour_controller_top_defines.svh"

module iflcc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] hue,
    input logic [7:0] saturation,
    input logic [7:0] level,
    input logic       light_write,
    input logic       reset_request
);

    `IFLCC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation) && $stable(level) && $stable(light_write) && $stable(reset_request), "result changed while stalled")
    `IFLCC_ASSERT(a_req_no_write, clk, rst_n, out_valid && reset_request |-> !light_write, "colour stepped on reset request")
    `IFLCC_ASSERT(a_full_only, clk, rst_n, !in_ready |-> out_valid, "input stalled with empty output")
    `IFLCC_ASSERT(a_result_next, clk, rst_n, in_valid && in_ready && !out_valid |=> out_valid, "accepted transfer gave no result")

endmodule

bind idle_fading_led_colour_controller_top iflcc_checker u_chk (.*);
